// File: rtl/shared_adc_endstop_sampler_core_assert.svh
// ----------------------------------------------------------------------------
// Shared ADC / endstop sampler assertion macros
// Concurrent assertion wrappers; they vanish when SYNTHESIS is defined.
// The modules that use them have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SHARED_ADC_ENDSTOP_SAMPLER_CORE_ASSERT_SVH
`define SHARED_ADC_ENDSTOP_SAMPLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SAES_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sampler assertion failed");
`define SAES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler sequencing assertion failed");
`else
`define SAES_ASSERT(lbl, prop)
`define SAES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/saes_pkg.sv
// ----------------------------------------------------------------------------
// Shared ADC / endstop sampler package
// Beat types, register indexes, phase and controller encodings, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package saes_pkg;

	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned TICK_W    = 32;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned CODE_W    = 8;
	localparam int unsigned SUM_W     = 20;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;

	typedef struct packed {
		logic                pin_level;
		logic                adc_ready;
		logic [SAMPLE_W-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic                adc_report_valid;
		logic [SAMPLE_W-1:0] adc_average;
		logic [TICK_W-1:0]   adc_next_time;
		logic                trigger_fired;
		logic [CODE_W-1:0]   trigger_code;
		logic                homing_active;
	} out_item_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ADC_SAMPLE_TICKS,
		REG_ADC_SAMPLE_COUNT,
		REG_ADC_REST_TICKS,
		REG_ES_SAMPLE_TICKS,
		REG_ES_SAMPLE_COUNT,
		REG_ES_REST_TICKS,
		REG_TRIGGER_LEVEL,
		REG_TRIGGER_REASON
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_POLL,
		PH_OVER,
		PH_DONE
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} ctrl_state_t;

	typedef struct packed {
		logic step;
		logic div_start;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic space;
		logic round_end;
		logic div_done;
	} ctrl_status_t;

endpackage

// File: rtl/saes_div.sv
// ----------------------------------------------------------------------------
// Sampler averaging divider
// Restoring divider, one quotient bit per cycle, for the round sum over the
// sample count.
// ----------------------------------------------------------------------------
module saes_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [saes_pkg::SUM_W-1:0]         dividend,
	input  logic [saes_pkg::COUNT_W-1:0]       divisor,
	output logic                               done,
	output logic [saes_pkg::SUM_W-1:0]         quotient
);

	localparam int unsigned CNT_W = $clog2(saes_pkg::SUM_W);

	logic                             busy_q;
	logic                             done_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [saes_pkg::SUM_W-1:0]       dq_q;
	logic [saes_pkg::COUNT_W-1:0]     rem_q;
	logic [saes_pkg::COUNT_W-1:0]     dv_q;
	logic [saes_pkg::COUNT_W:0]       rem_shift;
	logic [saes_pkg::COUNT_W:0]       rem_next;
	logic                             qbit;

	always_comb begin
		rem_shift = {rem_q, dq_q[saes_pkg::SUM_W-1]};
		qbit      = (rem_shift >= {1'b0, dv_q});
		rem_next  = qbit ? (rem_shift - {1'b0, dv_q}) : rem_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(saes_pkg::SUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[saes_pkg::SUM_W-2:0], qbit};
			rem_q <= rem_next[saes_pkg::COUNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// File: rtl/saes_obuf.sv
// ----------------------------------------------------------------------------
// Sampler result buffer
// Two-entry output stage: a main register on the port and a skid register
// behind it, so that a new beat may be taken while a result waits.
// ----------------------------------------------------------------------------
`include "shared_adc_endstop_sampler_core_assert.svh"

module saes_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  saes_pkg::out_item_t   load_data,
	output logic                  space,
	output logic                  out_valid,
	input  logic                  out_stall,
	output saes_pkg::out_item_t   out_data
);

	logic                 main_valid_q;
	logic                 skid_valid_q;
	saes_pkg::out_item_t  main_q;
	saes_pkg::out_item_t  skid_q;
	logic                 take;
	logic                 main_free;

	assign take      = main_valid_q && !out_stall;
	assign main_free = take || !main_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || load;
			skid_valid_q <= skid_valid_q && load;
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (load) begin
					skid_q <= load_data;
				end
			end else if (load) begin
				main_q <= load_data;
			end
		end else if (load) begin
			skid_q <= load_data;
		end
	end

	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	`SAES_ASSERT(a_load_has_room, load |-> !skid_valid_q)
	`SAES_ASSERT(a_skid_behind_main, skid_valid_q |-> main_valid_q)
	`SAES_ASSERT_NEXT(a_drain_empties, main_valid_q && !out_stall && !skid_valid_q && !load, !main_valid_q)

endmodule

// File: rtl/saes_ctrl.sv
// ----------------------------------------------------------------------------
// Sampler controller
// Takes input beats when the result buffer has room and holds the input
// while the averaging divider runs at the end of a round.
// ----------------------------------------------------------------------------
`include "shared_adc_endstop_sampler_core_assert.svh"

module saes_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  saes_pkg::ctrl_status_t  status,
	output saes_pkg::ctrl_cmd_t     cmd
);

	saes_pkg::ctrl_state_t state_q;
	saes_pkg::ctrl_state_t state_d;
	logic                  accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= saes_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			saes_pkg::ST_IDLE: begin
				if (in_valid && status.space && status.round_end) begin
					state_d = saes_pkg::ST_DIV;
				end
			end
			saes_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_d = saes_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = saes_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		accept        = 1'b0;
		cmd           = '0;
		case (state_q)
			saes_pkg::ST_IDLE: begin
				in_stall      = !status.space;
				accept        = in_valid && status.space;
				cmd.step      = accept;
				cmd.div_start = accept && status.round_end;
			end
			saes_pkg::ST_DIV: begin
				cmd.finish = status.div_done;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	`SAES_ASSERT(a_step_needs_room, cmd.step |-> status.space)
	`SAES_ASSERT(a_done_only_dividing, status.div_done |-> state_q == saes_pkg::ST_DIV)
	`SAES_ASSERT_NEXT(a_div_entered, cmd.div_start, state_q == saes_pkg::ST_DIV)
	`SAES_ASSERT_NEXT(a_finish_returns, cmd.finish, state_q == saes_pkg::ST_IDLE)

endmodule

// File: rtl/saes_dp.sv
// ----------------------------------------------------------------------------
// Sampler datapath
// Configuration registers, tick timer, ADC round accumulation and the
// endstop polling and oversampling state, with result assembly.
// ----------------------------------------------------------------------------
module saes_dp #(
	parameter int unsigned ADC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  saes_pkg::reg_idx_t                    cfg_idx,
	input  logic [saes_pkg::DATA_W-1:0]           cfg_wdata,
	input  saes_pkg::reg_idx_t                    rd_idx,
	output logic [saes_pkg::DATA_W-1:0]           rd_data,
	input  saes_pkg::in_item_t                    in_item,
	input  saes_pkg::ctrl_cmd_t                   cmd,
	output logic                                  round_end,
	output logic [saes_pkg::SUM_W-1:0]            div_dividend,
	output logic [saes_pkg::COUNT_W-1:0]          div_divisor,
	input  logic [saes_pkg::SUM_W-1:0]            div_quotient,
	output logic                                  res_load,
	output saes_pkg::out_item_t                   res_item
);

	localparam int unsigned TW = saes_pkg::TICK_W;
	localparam int unsigned CW = saes_pkg::COUNT_W;
	localparam int unsigned SW = saes_pkg::SAMPLE_W;
	localparam int unsigned MASK_BITS = (ADC_BITS < SW) ? ADC_BITS : SW;
	localparam logic [SW-1:0] SAMPLE_MASK = SW'((1 << MASK_BITS) - 1);
	localparam logic [TW-1:0] HALF_MAX = {1'b0, {(TW-1){1'b1}}};

	function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] x);
		return (x == '0) ? TW'(1) : x;
	endfunction

	function automatic logic [TW-1:0] dec_floor(input logic [TW-1:0] x);
		return (x == '0) ? '0 : (x - 1'b1);
	endfunction

	logic [TW-1:0]              adc_sample_ticks_q;
	logic [CW-1:0]              adc_sample_count_q;
	logic [TW-1:0]              adc_rest_ticks_q;
	logic [TW-1:0]              es_sample_ticks_q;
	logic [CW-1:0]              es_sample_count_q;
	logic [TW-1:0]              es_rest_ticks_q;
	logic                       trigger_level_q;
	logic [saes_pkg::CODE_W-1:0] trigger_reason_q;

	logic [TW-1:0]              tick_time_q;
	logic [TW-1:0]              wait_q;
	logic [TW-1:0]              round_start_q;
	logic [saes_pkg::SUM_W-1:0] sum_q;
	logic [CW-1:0]              taken_q;
	saes_pkg::phase_t           phase_q;
	logic [CW-1:0]              matches_q;
	logic [TW-1:0]              resume_q;
	logic [TW-1:0]              last_time_q;

	logic [TW-1:0]              wait_d;
	logic [TW-1:0]              round_start_d;
	logic [saes_pkg::SUM_W-1:0] sum_d;
	logic [CW-1:0]              taken_d;
	saes_pkg::phase_t           phase_d;
	logic [CW-1:0]              matches_d;
	logic [TW-1:0]              resume_mid;
	logic [TW-1:0]              resume_d;
	logic                       fired;
	logic [saes_pkg::CODE_W-1:0] code;
	logic [SW-1:0]              sample_m;
	logic [saes_pkg::SUM_W-1:0] sum_new;
	logic [CW-1:0]              taken_new;
	logic [TW-1:0]              rest_eff;
	logic [TW-1:0]              wait_fin;
	logic                       adc_restart_ok;
	saes_pkg::out_item_t        step_res;
	saes_pkg::out_item_t        fin_res;

	assign sample_m  = in_item.adc_sample & SAMPLE_MASK;
	assign sum_new   = sum_q + saes_pkg::SUM_W'(sample_m);
	assign taken_new = taken_q + 1'b1;
	assign rest_eff  = at_least_one(adc_rest_ticks_q);
	assign wait_fin  = round_start_q + ~last_time_q;

	always_comb begin
		wait_d        = wait_q;
		round_start_d = round_start_q;
		sum_d         = sum_q;
		taken_d       = taken_q;
		phase_d       = phase_q;
		matches_d     = matches_q;
		resume_mid    = resume_q;
		fired         = 1'b0;
		code          = '0;
		round_end     = 1'b0;
		if (es_sample_count_q != '0) begin
			if (phase_q != saes_pkg::PH_DONE) begin
				if (wait_q != '0) begin
					wait_d = wait_q - 1'b1;
				end else if (in_item.pin_level != trigger_level_q) begin
					if (phase_q == saes_pkg::PH_POLL) begin
						wait_d = dec_floor(es_rest_ticks_q);
					end else begin
						phase_d   = saes_pkg::PH_POLL;
						matches_d = es_sample_count_q;
						wait_d    = dec_floor(resume_q);
					end
				end else begin
					if (phase_q == saes_pkg::PH_POLL) begin
						resume_mid = at_least_one(es_rest_ticks_q);
						phase_d    = saes_pkg::PH_OVER;
					end
					if (matches_q <= CW'(1)) begin
						matches_d = '0;
						phase_d   = saes_pkg::PH_DONE;
						fired     = 1'b1;
						code      = trigger_reason_q;
					end else begin
						matches_d = matches_q - 1'b1;
						wait_d    = dec_floor(es_sample_ticks_q);
					end
				end
			end
		end else if (adc_sample_count_q != '0) begin
			if (wait_q != '0) begin
				wait_d = wait_q - 1'b1;
			end else if (in_item.adc_ready) begin
				if (taken_new < adc_sample_count_q) begin
					sum_d   = sum_new;
					taken_d = taken_new;
					wait_d  = dec_floor(adc_sample_ticks_q);
				end else begin
					round_end     = 1'b1;
					sum_d         = '0;
					taken_d       = '0;
					round_start_d = round_start_q + rest_eff;
				end
			end
		end
		resume_d = dec_floor(resume_mid);
	end

	always_comb begin
		step_res                  = '0;
		step_res.trigger_fired    = fired;
		step_res.trigger_code     = code;
		step_res.homing_active    = (es_sample_count_q != '0) && (phase_d != saes_pkg::PH_DONE);
		fin_res                   = '0;
		fin_res.adc_report_valid  = 1'b1;
		fin_res.adc_average       = div_quotient[SW-1:0] & SAMPLE_MASK;
		fin_res.adc_next_time     = round_start_q;
		res_item                  = cmd.finish ? fin_res : step_res;
		res_load                  = cmd.finish || (cmd.step && !round_end);
	end

	assign div_dividend = sum_new;
	assign div_divisor  = adc_sample_count_q;

	always_comb begin
		adc_restart_ok = (es_sample_count_q == '0) && (adc_sample_count_q != '0);
		if (cfg_idx == saes_pkg::REG_ADC_SAMPLE_COUNT) begin
			adc_restart_ok = (es_sample_count_q == '0) && (cfg_wdata[CW-1:0] != '0);
		end
	end

	always_comb begin
		case (rd_idx)
			saes_pkg::REG_ADC_SAMPLE_TICKS: rd_data = adc_sample_ticks_q;
			saes_pkg::REG_ADC_SAMPLE_COUNT: rd_data = saes_pkg::DATA_W'(adc_sample_count_q);
			saes_pkg::REG_ADC_REST_TICKS:   rd_data = adc_rest_ticks_q;
			saes_pkg::REG_ES_SAMPLE_TICKS:  rd_data = es_sample_ticks_q;
			saes_pkg::REG_ES_SAMPLE_COUNT:  rd_data = saes_pkg::DATA_W'(es_sample_count_q);
			saes_pkg::REG_ES_REST_TICKS:    rd_data = es_rest_ticks_q;
			saes_pkg::REG_TRIGGER_LEVEL:    rd_data = saes_pkg::DATA_W'(trigger_level_q);
			saes_pkg::REG_TRIGGER_REASON:   rd_data = saes_pkg::DATA_W'(trigger_reason_q);
			default:                        rd_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_sample_ticks_q <= TW'(1);
			adc_sample_count_q <= '0;
			adc_rest_ticks_q   <= TW'(1);
			es_sample_ticks_q  <= TW'(1);
			es_sample_count_q  <= '0;
			es_rest_ticks_q    <= TW'(1);
			trigger_level_q    <= 1'b0;
			trigger_reason_q   <= '0;
			tick_time_q        <= '0;
			wait_q             <= '0;
			round_start_q      <= '0;
			sum_q              <= '0;
			taken_q            <= '0;
			phase_q            <= saes_pkg::PH_POLL;
			matches_q          <= '0;
			resume_q           <= '0;
			last_time_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				saes_pkg::REG_ADC_SAMPLE_TICKS,
				saes_pkg::REG_ADC_SAMPLE_COUNT,
				saes_pkg::REG_ADC_REST_TICKS: begin
					if (cfg_idx == saes_pkg::REG_ADC_SAMPLE_TICKS) begin
						adc_sample_ticks_q <= cfg_wdata[TW-1:0];
					end
					if (cfg_idx == saes_pkg::REG_ADC_SAMPLE_COUNT) begin
						adc_sample_count_q <= cfg_wdata[CW-1:0];
					end
					if (cfg_idx == saes_pkg::REG_ADC_REST_TICKS) begin
						adc_rest_ticks_q <= cfg_wdata[TW-1:0];
					end
					sum_q   <= '0;
					taken_q <= '0;
					if (adc_restart_ok) begin
						round_start_q <= tick_time_q;
						wait_q        <= '0;
					end
				end
				saes_pkg::REG_ES_SAMPLE_TICKS: begin
					es_sample_ticks_q <= cfg_wdata[TW-1:0];
				end
				saes_pkg::REG_ES_SAMPLE_COUNT: begin
					es_sample_count_q <= cfg_wdata[CW-1:0];
					phase_q           <= saes_pkg::PH_POLL;
					matches_q         <= cfg_wdata[CW-1:0];
					resume_q          <= '0;
					sum_q             <= '0;
					taken_q           <= '0;
					if (cfg_wdata[CW-1:0] != '0) begin
						wait_q <= '0;
					end else if (adc_sample_count_q != '0) begin
						round_start_q <= tick_time_q + rest_eff;
						wait_q        <= rest_eff;
					end
				end
				saes_pkg::REG_ES_REST_TICKS: begin
					es_rest_ticks_q <= cfg_wdata[TW-1:0];
				end
				saes_pkg::REG_TRIGGER_LEVEL: begin
					trigger_level_q <= cfg_wdata[0];
				end
				saes_pkg::REG_TRIGGER_REASON: begin
					trigger_reason_q <= cfg_wdata[saes_pkg::CODE_W-1:0];
				end
				default: begin
					trigger_reason_q <= trigger_reason_q;
				end
			endcase
		end else if (cmd.step) begin
			tick_time_q   <= tick_time_q + 1'b1;
			wait_q        <= wait_d;
			round_start_q <= round_start_d;
			sum_q         <= sum_d;
			taken_q       <= taken_d;
			phase_q       <= phase_d;
			matches_q     <= matches_d;
			resume_q      <= resume_d;
			if (round_end) begin
				last_time_q <= tick_time_q;
			end
		end else if (cmd.finish) begin
			wait_q <= (!wait_fin[TW-1] && (wait_fin != HALF_MAX)) ? wait_fin : '0;
		end
	end

endmodule

// File: rtl/shared_adc_endstop_sampler_core.sv
// ----------------------------------------------------------------------------
// Shared ADC / endstop sampler core
// One input beat is one timer tick. In ADC mode conversions are averaged
// over rounds; in homing mode the pin is polled and oversampled until the
// trigger is confirmed.
//
//   Channel   Direction  Handshake                  Beat
//   in        in         in_valid / in_stall        in_item_t
//   out       out        out_valid / out_stall      out_item_t
//   config    in         psel/penable/pwrite APB    32-bit register
//
// After the tick that closes an ADC round, input is held while the average
// comes from a divider that resolves one quotient bit per cycle over the
// 20-bit round sum.
// Results queue in a two-entry buffer; input stalls when its second entry
// is full or while the divider runs.
// Reset restores state and config registers at once; no clearing pass.
// ----------------------------------------------------------------------------
module shared_adc_endstop_sampler_core #(
	parameter int unsigned ADC_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  saes_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output saes_pkg::out_item_t                  out_data,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [saes_pkg::ADDR_W-1:0]          paddr,
	input  logic [saes_pkg::DATA_W-1:0]          pwdata,
	output logic [saes_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	saes_pkg::ctrl_cmd_t          cmd;
	saes_pkg::ctrl_status_t       status;
	saes_pkg::reg_idx_t           reg_idx;
	saes_pkg::out_item_t          res_item;
	logic                         cfg_we;
	logic                         round_end;
	logic                         res_load;
	logic                         space;
	logic                         div_done;
	logic [saes_pkg::SUM_W-1:0]   div_dividend;
	logic [saes_pkg::COUNT_W-1:0] div_divisor;
	logic [saes_pkg::SUM_W-1:0]   div_quotient;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_idx = saes_pkg::reg_idx_t'(paddr[saes_pkg::ADDR_W-1:2]);

	assign status.space     = space;
	assign status.round_end = round_end;
	assign status.div_done  = div_done;

	saes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	saes_dp #(
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (reg_idx),
		.cfg_wdata    (pwdata),
		.rd_idx       (reg_idx),
		.rd_data      (prdata),
		.in_item      (in_data),
		.cmd          (cmd),
		.round_end    (round_end),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_quotient (div_quotient),
		.res_load     (res_load),
		.res_item     (res_item)
	);

	saes_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	saes_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.load_data (res_item),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
